/* hdl/lcdbs_pkg.sv */
// ----------------------------------------------------------------------------
// lcdbs_pkg
// Shared types and constants for the character LCD bus sequencer.
// ----------------------------------------------------------------------------
package lcdbs_pkg;

    localparam int TIMER_WIDTH_DEFAULT = 24;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam int CFG_DATA_WIDTH  = 24;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ENABLE_HIGH = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ENABLE_LOW  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_POWER_WAIT  = 2'd2;

    localparam logic [7:0]  ENABLE_HIGH_RESET = 8'd12;
    localparam logic [7:0]  ENABLE_LOW_RESET  = 8'd14;
    localparam logic [23:0] POWER_WAIT_RESET  = 24'd1000000;

    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_INIT     = 3'd1;
    localparam logic [2:0] CMD_CHAR     = 3'd2;
    localparam logic [2:0] CMD_CURSOR   = 3'd3;
    localparam logic [2:0] CMD_POSITION = 3'd4;
    localparam logic [2:0] CMD_CLEAR    = 3'd5;
    localparam logic [2:0] CMD_HOME     = 3'd6;

    localparam logic [7:0] INSTR_FUNCTION_SET = 8'h38;
    localparam logic [7:0] INSTR_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] INSTR_CLEAR        = 8'h01;
    localparam logic [7:0] INSTR_HOME         = 8'h02;

    localparam int BUSY_BIT = 7;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_INIT,
        KIND_WRITE
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_POWER_WAIT,
        PH_POLL_HIGH,
        PH_POLL_LOW_BUSY,
        PH_POLL_LOW_FREE,
        PH_WRITE_HIGH,
        PH_WRITE_LOW
    } phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] byte_val;
        logic       is_data;
        logic [7:0] bus;
    } queue_item_t;

    typedef struct packed {
        logic       reg_select;
        logic       read_write;
        logic       enable;
        logic [7:0] data_out;
        logic       data_drive;
        logic       power_on;
        logic       ready_res;
    } result_t;

    typedef struct packed {
        logic [7:0]  enable_high_ticks;
        logic [7:0]  enable_low_ticks;
        logic [23:0] power_wait_ticks;
    } cfg_t;

endpackage

/* hdl/lcdbs_fifo.sv */
// ----------------------------------------------------------------------------
// lcdbs_fifo
// Small register queue with registered occupancy, used between stages.
// ----------------------------------------------------------------------------
module lcdbs_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* hdl/lcdbs_front.sv */
// ----------------------------------------------------------------------------
// lcdbs_front
// Decodes a request into the byte to write and its kind.
// ----------------------------------------------------------------------------
module lcdbs_front (
    input  logic [2:0]                cmd,
    input  logic [7:0]                char_code,
    input  logic                      cursor_on,
    input  logic                      cursor_blink,
    input  logic                      row,
    input  logic [5:0]                column,
    input  logic [7:0]                bus_in,
    output lcdbs_pkg::queue_item_t    item
);

    import lcdbs_pkg::*;

    always_comb
    begin
        item.kind     = KIND_WRITE;
        item.byte_val = '0;
        item.is_data  = 1'b0;
        item.bus      = bus_in;
        case (cmd)
            CMD_INIT:
            begin
                item.kind = KIND_INIT;
            end
            CMD_CHAR:
            begin
                item.byte_val = char_code;
                item.is_data  = 1'b1;
            end
            CMD_CURSOR:
            begin
                item.byte_val = INSTR_DISPLAY_ON | {6'b0, cursor_on, cursor_blink};
            end
            CMD_POSITION:
            begin
                // Column is below 64, so the set-address sum never carries.
                item.byte_val = {1'b1, row, column};
            end
            CMD_CLEAR:
            begin
                item.byte_val = INSTR_CLEAR;
            end
            CMD_HOME:
            begin
                item.byte_val = INSTR_HOME;
            end
            default:
            begin
                item.kind = KIND_NONE;
            end
        endcase
    end

endmodule

/* hdl/lcdbs_back.sv */
// ----------------------------------------------------------------------------
// lcdbs_back
// Pin sequencer: power-up wait, busy polling and enable-strobed writes.
// ----------------------------------------------------------------------------
module lcdbs_back #(
    parameter int TIMER_WIDTH = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lcdbs_pkg::cfg_t        cfg,
    input  lcdbs_pkg::queue_item_t item,
    input  logic                   item_valid,
    output logic                   item_pop,
    input  logic                   res_full,
    output logic                   res_push,
    output lcdbs_pkg::result_t     res
);

    import lcdbs_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;
    logic [7:0]             byte_reg, byte_next;
    logic                   is_data_reg, is_data_next;
    logic                   second_reg, second_next;
    logic                   powered_reg, powered_next;
    logic                   step;
    logic [TIMER_WIDTH-1:0] lim_raw;
    logic [TIMER_WIDTH-1:0] lim;
    logic [TIMER_WIDTH:0]   timer_inc;
    logic                   done;
    logic [TIMER_WIDTH-1:0] timer_count;

    always_comb
    begin
        step     = item_valid && !res_full;
        item_pop = step;
        res_push = step;

        res.reg_select = 1'b0;
        res.read_write = 1'b0;
        res.enable     = 1'b0;
        res.data_out   = '0;
        res.data_drive = 1'b0;
        res.power_on   = powered_reg;
        res.ready_res  = (phase_reg == PH_IDLE);

        case (phase_reg)
            PH_POWER_WAIT:    lim_raw = TIMER_WIDTH'(cfg.power_wait_ticks);
            PH_POLL_HIGH:     lim_raw = TIMER_WIDTH'(cfg.enable_high_ticks);
            PH_WRITE_HIGH:    lim_raw = TIMER_WIDTH'(cfg.enable_high_ticks);
            PH_POLL_LOW_BUSY: lim_raw = TIMER_WIDTH'(cfg.enable_low_ticks);
            PH_POLL_LOW_FREE: lim_raw = TIMER_WIDTH'(cfg.enable_low_ticks);
            PH_WRITE_LOW:     lim_raw = TIMER_WIDTH'(cfg.enable_low_ticks);
            default:          lim_raw = '0;
        endcase
        lim         = (lim_raw == '0) ? TIMER_WIDTH'(1) : lim_raw;
        timer_inc   = {1'b0, timer_reg} + 1'b1;
        done        = (timer_inc >= {1'b0, lim});
        timer_count = done ? '0 : timer_inc[TIMER_WIDTH-1:0];

        case (phase_reg)
            PH_POLL_HIGH:
            begin
                res.read_write = 1'b1;
                res.enable     = 1'b1;
            end
            PH_POLL_LOW_BUSY,
            PH_POLL_LOW_FREE:
            begin
                res.read_write = 1'b1;
            end
            PH_WRITE_HIGH:
            begin
                res.enable     = 1'b1;
                res.reg_select = is_data_reg;
                res.data_out   = byte_reg;
                res.data_drive = 1'b1;
            end
            PH_WRITE_LOW:
            begin
                res.reg_select = is_data_reg;
                res.data_out   = byte_reg;
                res.data_drive = 1'b1;
            end
            default:
            begin
            end
        endcase

        phase_next   = phase_reg;
        timer_next   = timer_reg;
        byte_next    = byte_reg;
        is_data_next = is_data_reg;
        second_next  = second_reg;
        powered_next = powered_reg;

        if (step)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (item.kind == KIND_INIT)
                    begin
                        powered_next = 1'b1;
                        second_next  = 1'b0;
                        timer_next   = '0;
                        phase_next   = PH_POWER_WAIT;
                    end
                    else if (powered_reg && item.kind == KIND_WRITE)
                    begin
                        byte_next    = item.byte_val;
                        is_data_next = item.is_data;
                        timer_next   = '0;
                        phase_next   = PH_POLL_HIGH;
                    end
                end
                PH_POWER_WAIT:
                begin
                    timer_next = timer_count;
                    if (done)
                    begin
                        second_next  = 1'b1;
                        byte_next    = INSTR_FUNCTION_SET;
                        is_data_next = 1'b0;
                        phase_next   = PH_POLL_HIGH;
                    end
                end
                PH_POLL_HIGH:
                begin
                    timer_next = timer_count;
                    if (done)
                    begin
                        phase_next = item.bus[BUSY_BIT] ? PH_POLL_LOW_BUSY : PH_POLL_LOW_FREE;
                    end
                end
                PH_POLL_LOW_BUSY:
                begin
                    timer_next = timer_count;
                    if (done)
                    begin
                        phase_next = PH_POLL_HIGH;
                    end
                end
                PH_POLL_LOW_FREE:
                begin
                    timer_next = timer_count;
                    if (done)
                    begin
                        phase_next = PH_WRITE_HIGH;
                    end
                end
                PH_WRITE_HIGH:
                begin
                    timer_next = timer_count;
                    if (done)
                    begin
                        phase_next = PH_WRITE_LOW;
                    end
                end
                PH_WRITE_LOW:
                begin
                    timer_next = timer_count;
                    if (done)
                    begin
                        if (second_reg)
                        begin
                            second_next  = 1'b0;
                            byte_next    = INSTR_DISPLAY_ON;
                            is_data_next = 1'b0;
                            phase_next   = PH_POLL_HIGH;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    timer_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            timer_reg   <= '0;
            byte_reg    <= '0;
            is_data_reg <= 1'b0;
            second_reg  <= 1'b0;
            powered_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            timer_reg   <= timer_next;
            byte_reg    <= byte_next;
            is_data_reg <= is_data_next;
            second_reg  <= second_next;
            powered_reg <= powered_next;
        end
    end

endmodule

/* hdl/char_lcd_bus_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer_unit
// Character LCD 8-bit bus sequencer; one input word is one sequencer tick.
//
//   Channel   Handshake            Contents
//   input     push / full          cmd, char_code, cursor_on, cursor_blink,
//                                  row, column, bus_in
//   result    empty / pop          reg_select, read_write, enable, data_out,
//                                  data_drive, power_on, ready_res
//   config    cfg_wr_en            cfg_index, cfg_wdata
//
// One word is taken per cycle while the input queue is not full; each word
// yields one result word (input queue, then sequencer into result queue).
// The sequencer steps once per word, and only while the result queue has room.
// Reset clears both queues and the sequencer and loads the default counts.
// Either side may stall; the queues hold words until the other side moves.
// ----------------------------------------------------------------------------
module char_lcd_bus_sequencer_unit #(
    parameter int TIMER_WIDTH = lcdbs_pkg::TIMER_WIDTH_DEFAULT,
    parameter int QUEUE_DEPTH = lcdbs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [2:0]                            cmd,
    input  logic [7:0]                            char_code,
    input  logic                                  cursor_on,
    input  logic                                  cursor_blink,
    input  logic                                  row,
    input  logic [5:0]                            column,
    input  logic [7:0]                            bus_in,
    output logic                                  empty,
    input  logic                                  pop,
    output logic                                  reg_select,
    output logic                                  read_write,
    output logic                                  enable,
    output logic [7:0]                            data_out,
    output logic                                  data_drive,
    output logic                                  power_on,
    output logic                                  ready_res,
    input  logic                                  cfg_wr_en,
    input  logic [lcdbs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [lcdbs_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);

    import lcdbs_pkg::*;

    localparam int ITEM_W = $bits(queue_item_t);
    localparam int RES_W  = $bits(result_t);

    cfg_t              cfg_reg, cfg_next;
    queue_item_t       front_item;
    queue_item_t       back_item;
    logic [ITEM_W-1:0] q_rdata;
    logic              q_empty;
    logic              q_pop;
    result_t           back_res;
    logic              res_push;
    logic              res_full;
    logic [RES_W-1:0]  res_rdata;
    result_t           res_head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ENABLE_HIGH: cfg_next.enable_high_ticks = cfg_wdata[7:0];
                REG_ENABLE_LOW:  cfg_next.enable_low_ticks  = cfg_wdata[7:0];
                REG_POWER_WAIT:  cfg_next.power_wait_ticks  = cfg_wdata[23:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_high_ticks <= ENABLE_HIGH_RESET;
            cfg_reg.enable_low_ticks  <= ENABLE_LOW_RESET;
            cfg_reg.power_wait_ticks  <= POWER_WAIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lcdbs_front u_front (
        .cmd          (cmd),
        .char_code    (char_code),
        .cursor_on    (cursor_on),
        .cursor_blink (cursor_blink),
        .row          (row),
        .column       (column),
        .bus_in       (bus_in),
        .item         (front_item)
    );

    lcdbs_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_item),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign back_item = queue_item_t'(q_rdata);

    lcdbs_back #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item       (back_item),
        .item_valid (!q_empty),
        .item_pop   (q_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (back_res)
    );

    lcdbs_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign res_head   = result_t'(res_rdata);
    assign reg_select = res_head.reg_select;
    assign read_write = res_head.read_write;
    assign enable     = res_head.enable;
    assign data_out   = res_head.data_out;
    assign data_drive = res_head.data_drive;
    assign power_on   = res_head.power_on;
    assign ready_res  = res_head.ready_res;

endmodule

/* hdl/lcdbs_checker.sv */
// ----------------------------------------------------------------------------
// lcdbs_checker
// Port-level checks on the result words of the bus sequencer.
// ----------------------------------------------------------------------------
module lcdbs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic       reg_select,
    input logic       read_write,
    input logic       enable,
    input logic [7:0] data_out,
    input logic       data_drive,
    input logic       power_on,
    input logic       ready_res
);

    // The pins are never driven during a status read.
    a_no_drive_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && data_drive) |-> !read_write)
        else $error("data pins driven during a status read");

    // Before power-up the bus stays quiet.
    a_quiet_unpowered: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !power_on) |->
        (!enable && !data_drive && !reg_select && !read_write && ready_res))
        else $error("bus active while the module is unpowered");

    // A ready word shows an idle bus.
    a_idle_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && ready_res) |-> (!enable && !data_drive && !read_write))
        else $error("bus active while ready");

    // Released data pins carry zero.
    a_zero_when_released: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !data_drive) |-> (data_out == 8'h00))
        else $error("data_out non-zero while pins released");

    // A word that is not taken stays in place.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(data_out) && $stable(enable)))
        else $error("waiting result word changed");

endmodule

bind char_lcd_bus_sequencer_unit lcdbs_checker u_lcdbs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .reg_select (reg_select),
    .read_write (read_write),
    .enable     (enable),
    .data_out   (data_out),
    .data_drive (data_drive),
    .power_on   (power_on),
    .ready_res  (ready_res)
);

/* verif/lcd_pin_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_pin_checker
// Watches the input, result and register channels of the LCD bus sequencer.
// Every accepted input word advances a private model of the sequencer by one
// tick, and the pin levels it predicts are queued. Every word popped from the
// result side is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lcd_pin_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    input  logic                                  full,
    input  logic [2:0]                            cmd,
    input  logic [7:0]                            char_code,
    input  logic                                  cursor_on,
    input  logic                                  cursor_blink,
    input  logic                                  row,
    input  logic [5:0]                            column,
    input  logic [7:0]                            bus_in,
    input  logic                                  empty,
    input  logic                                  pop,
    input  logic                                  reg_select,
    input  logic                                  read_write,
    input  logic                                  enable,
    input  logic [7:0]                            data_out,
    input  logic                                  data_drive,
    input  logic                                  power_on,
    input  logic                                  ready_res,
    input  logic                                  cfg_wr_en,
    input  logic [lcdbs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [lcdbs_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
    output int                                    mismatches,
    output int                                    words_owed
);

    import lcdbs_pkg::*;

    localparam logic [7:0] SET_DDRAM_ADDR = 8'h80;

    logic [7:0]  high_ticks;
    logic [7:0]  low_ticks;
    logic [23:0] power_ticks;

    phase_t      seq_phase;
    logic [23:0] tick_cnt;
    logic [7:0]  pend_byte;
    logic        pend_data;
    logic        second_pending;
    logic        powered;

    result_t     expected_pins[$];
    result_t     want;
    result_t     got;
    int          fail_count;

    function automatic logic tick_done(input logic [23:0] limit);
        logic [24:0] lim;
        logic [24:0] nxt;
        lim = {1'b0, limit};
        if (lim == '0)
            lim = 25'd1;
        nxt = {1'b0, tick_cnt} + 25'd1;
        if (nxt >= lim)
        begin
            tick_cnt = '0;
            return 1'b1;
        end
        tick_cnt = nxt[23:0];
        return 1'b0;
    endfunction

    function automatic void queue_write(input logic [7:0] value, input logic is_data);
        pend_byte = value;
        pend_data = is_data;
        tick_cnt  = '0;
        seq_phase = PH_POLL_HIGH;
    endfunction

    function automatic result_t advance_sequencer(
        input logic [2:0] req,
        input logic [7:0] ch,
        input logic       on,
        input logic       blink,
        input logic       line_sel,
        input logic [5:0] col_sel,
        input logic [7:0] bus
    );
        result_t pins;
        pins           = '0;
        pins.power_on  = powered;
        pins.ready_res = (seq_phase == PH_IDLE);
        case (seq_phase)
            PH_POLL_HIGH:
            begin
                pins.read_write = 1'b1;
                pins.enable     = 1'b1;
            end
            PH_POLL_LOW_BUSY, PH_POLL_LOW_FREE:
                pins.read_write = 1'b1;
            PH_WRITE_HIGH, PH_WRITE_LOW:
            begin
                pins.enable     = (seq_phase == PH_WRITE_HIGH);
                pins.reg_select = pend_data;
                pins.data_out   = pend_byte;
                pins.data_drive = 1'b1;
            end
            default: ;
        endcase

        case (seq_phase)
            PH_IDLE:
            begin
                if (req == CMD_INIT)
                begin
                    powered        = 1'b1;
                    second_pending = 1'b0;
                    tick_cnt       = '0;
                    seq_phase      = PH_POWER_WAIT;
                end
                else if (powered)
                begin
                    case (req)
                        CMD_CHAR:     queue_write(ch, 1'b1);
                        CMD_CURSOR:   queue_write(INSTR_DISPLAY_ON | {6'b0, on, blink}, 1'b0);
                        CMD_POSITION: queue_write(SET_DDRAM_ADDR + {1'b0, line_sel, col_sel}, 1'b0);
                        CMD_CLEAR:    queue_write(INSTR_CLEAR, 1'b0);
                        CMD_HOME:     queue_write(INSTR_HOME, 1'b0);
                        default: ;
                    endcase
                end
            end
            PH_POWER_WAIT:
            begin
                if (tick_done(power_ticks))
                begin
                    second_pending = 1'b1;
                    queue_write(INSTR_FUNCTION_SET, 1'b0);
                end
            end
            PH_POLL_HIGH:
            begin
                if (tick_done({16'b0, high_ticks}))
                    seq_phase = bus[BUSY_BIT] ? PH_POLL_LOW_BUSY : PH_POLL_LOW_FREE;
            end
            PH_POLL_LOW_BUSY:
            begin
                if (tick_done({16'b0, low_ticks}))
                    seq_phase = PH_POLL_HIGH;
            end
            PH_POLL_LOW_FREE:
            begin
                if (tick_done({16'b0, low_ticks}))
                    seq_phase = PH_WRITE_HIGH;
            end
            PH_WRITE_HIGH:
            begin
                if (tick_done({16'b0, high_ticks}))
                    seq_phase = PH_WRITE_LOW;
            end
            PH_WRITE_LOW:
            begin
                if (tick_done({16'b0, low_ticks}))
                begin
                    if (second_pending)
                    begin
                        second_pending = 1'b0;
                        queue_write(INSTR_DISPLAY_ON, 1'b0);
                    end
                    else
                    begin
                        seq_phase = PH_IDLE;
                    end
                end
            end
            default:
            begin
                seq_phase = PH_IDLE;
                tick_cnt  = '0;
            end
        endcase
        return pins;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: %s wrong, expected %02h, got %02h", $realtime, name, exp_v, act_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_ticks     = ENABLE_HIGH_RESET;
            low_ticks      = ENABLE_LOW_RESET;
            power_ticks    = POWER_WAIT_RESET;
            seq_phase      = PH_IDLE;
            tick_cnt       = '0;
            pend_byte      = '0;
            pend_data      = 1'b0;
            second_pending = 1'b0;
            powered        = 1'b0;
            expected_pins.delete();
            fail_count     = 0;
            mismatches     <= 0;
            words_owed     <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                got = '{reg_select, read_write, enable, data_out, data_drive, power_on,
                        ready_res};
                if (expected_pins.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result word popped with no prediction waiting", $realtime);
                end
                else
                begin
                    want = expected_pins.pop_front();
                    check_field("reg_select", 8'(want.reg_select), 8'(got.reg_select));
                    check_field("read_write", 8'(want.read_write), 8'(got.read_write));
                    check_field("enable", 8'(want.enable), 8'(got.enable));
                    check_field("data_out", want.data_out, got.data_out);
                    check_field("data_drive", 8'(want.data_drive), 8'(got.data_drive));
                    check_field("power_on", 8'(want.power_on), 8'(got.power_on));
                    check_field("ready_res", 8'(want.ready_res), 8'(got.ready_res));
                end
            end
            if (push && !full)
                expected_pins.push_back(advance_sequencer(cmd, char_code, cursor_on,
                                                          cursor_blink, row, column, bus_in));
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_ENABLE_HIGH: high_ticks  = cfg_wdata[7:0];
                    REG_ENABLE_LOW:  low_ticks   = cfg_wdata[7:0];
                    REG_POWER_WAIT:  power_ticks = cfg_wdata[23:0];
                    default: ;
                endcase
            end
            words_owed <= expected_pins.size();
            mismatches <= fail_count;
        end
    end

endmodule

/* verif/char_lcd_bus_sequencer_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer_unit_tb
// Drives the LCD bus sequencer with a directed opening (requests before power
// up, every request type, cursor and position corners, repeated init, busy
// overlap) and then with random tick streams under several enable and power
// wait settings. The sender works in bursts, the receiver stalls on a pattern
// of its own, and a separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module char_lcd_bus_sequencer_unit_tb;
    import lcdbs_pkg::*;

    localparam logic [2:0] CMD_UNUSED  = 3'd7;
    localparam int         CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] char_code;
        logic       cursor_on;
        logic       cursor_blink;
        logic       row;
        logic [5:0] column;
        logic [7:0] bus_in;
    } lcd_word_t;

    logic                       clk;
    logic                       rst_n        = 1'b0;
    logic                       push         = 1'b0;
    logic                       full;
    logic [2:0]                 cmd          = CMD_NONE;
    logic [7:0]                 char_code    = '0;
    logic                       cursor_on    = 1'b0;
    logic                       cursor_blink = 1'b0;
    logic                       row          = 1'b0;
    logic [5:0]                 column       = '0;
    logic [7:0]                 bus_in       = '0;
    logic                       empty;
    logic                       pop          = 1'b0;
    logic                       reg_select;
    logic                       read_write;
    logic                       enable;
    logic [7:0]                 data_out;
    logic                       data_drive;
    logic                       power_on;
    logic                       ready_res;
    logic                       cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index    = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_wdata    = '0;

    int   mismatches;
    int   words_owed;
    logic last_ready;
    int   cycles      = 0;
    int   burst_left  = 0;
    bit   steady      = 1'b1;

    char_lcd_bus_sequencer_unit dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd(cmd),
        .char_code(char_code), .cursor_on(cursor_on), .cursor_blink(cursor_blink),
        .row(row), .column(column), .bus_in(bus_in), .empty(empty), .pop(pop),
        .reg_select(reg_select), .read_write(read_write), .enable(enable),
        .data_out(data_out), .data_drive(data_drive), .power_on(power_on),
        .ready_res(ready_res), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    lcd_pin_checker u_check (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd(cmd),
        .char_code(char_code), .cursor_on(cursor_on), .cursor_blink(cursor_blink),
        .row(row), .column(column), .bus_in(bus_in), .empty(empty), .pop(pop),
        .reg_select(reg_select), .read_write(read_write), .enable(enable),
        .data_out(data_out), .data_drive(data_drive), .power_on(power_on),
        .ready_res(ready_res), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .mismatches(mismatches), .words_owed(words_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // The last popped word tells whether the sequencer sat idle on its final tick.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_ready <= 1'b0;
        else if (pop && !empty)
            last_ready <= ready_res;
    end

    initial
    begin : receiver
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            case (mode)
                0:       pop <= 1'b1;
                1:       pop <= ($urandom_range(0, 3) != 0);
                2:       pop <= ((left % 7) >= 3);
                default: pop <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    function automatic lcd_word_t make_word(input logic [2:0] c, input logic [7:0] ch,
                                            input logic on, input logic blink,
                                            input logic line_sel, input logic [5:0] col);
        lcd_word_t w;
        w.cmd          = c;
        w.char_code    = ch;
        w.cursor_on    = on;
        w.cursor_blink = blink;
        w.row          = line_sel;
        w.column       = col;
        w.bus_in       = {($urandom_range(0, 99) < 25), 7'($urandom)};
        return w;
    endfunction

    function automatic lcd_word_t random_word();
        int         pick;
        logic [2:0] c;
        logic [5:0] col;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            c = CMD_NONE;
        else if (pick < 48)
            c = CMD_INIT;
        else if (pick < 50)
            c = CMD_UNUSED;
        else
            c = 3'($urandom_range(CMD_CHAR, CMD_HOME));
        col = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(40, 63))
                                          : 6'($urandom_range(0, 39));
        return make_word(c, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), col);
    endfunction

    task automatic send_word(input lcd_word_t w);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if (!steady && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 8);
        end
        burst_left--;
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        cmd          <= w.cmd;
        char_code    <= w.char_code;
        cursor_on    <= w.cursor_on;
        cursor_blink <= w.cursor_blink;
        row          <= w.row;
        column       <= w.column;
        bus_in       <= w.bus_in;
        push         <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (words_owed != 0)
            @(posedge clk);
    endtask

    // Idle words are sent in short batches until a batch ends with the sequencer idle.
    task automatic wait_idle();
        do
        begin
            repeat (4)
                send_word(make_word(CMD_NONE, 8'($urandom), 1'($urandom), 1'($urandom),
                                    1'($urandom), 6'($urandom)));
            drain();
        end
        while (!last_ready);
    endtask

    task automatic do_request(input logic [2:0] c, input logic [7:0] ch, input logic on,
                              input logic blink, input logic line_sel,
                              input logic [5:0] col);
        send_word(make_word(c, ch, on, blink, line_sel, col));
        wait_idle();
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] high_t, input logic [7:0] low_t,
                             input logic [23:0] wait_t, input int words, input bit calm);
        wait_idle();
        write_reg(REG_ENABLE_HIGH, {16'b0, high_t});
        write_reg(REG_ENABLE_LOW, {16'b0, low_t});
        write_reg(REG_POWER_WAIT, wait_t);
        steady = calm;
        repeat (words)
            send_word(random_word());
    endtask

    initial
    begin
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Short strobe counts keep the directed part brief.
        write_reg(REG_ENABLE_HIGH, 24'd1);
        write_reg(REG_ENABLE_LOW, 24'd2);

        // Requests before power up are dropped.
        do_request(CMD_CHAR, 8'hA5, 1'b0, 1'b0, 1'b0, 6'd0);
        do_request(CMD_POSITION, 8'h00, 1'b0, 1'b0, 1'b1, 6'd5);
        do_request(CMD_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b1, 6'd63);

        write_reg(REG_POWER_WAIT, 24'hFFFFFF);
        write_reg(REG_POWER_WAIT, 24'd0);
        do_request(CMD_INIT, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0);

        do_request(CMD_CHAR, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0);
        do_request(CMD_CHAR, 8'hFF, 1'b1, 1'b1, 1'b1, 6'd63);
        do_request(CMD_CURSOR, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0);
        do_request(CMD_CURSOR, 8'h00, 1'b0, 1'b1, 1'b0, 6'd0);
        do_request(CMD_CURSOR, 8'h00, 1'b1, 1'b0, 1'b0, 6'd0);
        do_request(CMD_CURSOR, 8'h00, 1'b1, 1'b1, 1'b0, 6'd0);
        do_request(CMD_POSITION, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0);
        do_request(CMD_POSITION, 8'h00, 1'b0, 1'b0, 1'b1, 6'd39);
        do_request(CMD_POSITION, 8'h00, 1'b0, 1'b0, 1'b1, 6'd63);
        do_request(CMD_POSITION, 8'h00, 1'b0, 1'b0, 1'b0, 6'd40);
        do_request(CMD_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0);
        do_request(CMD_HOME, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0);
        do_request(CMD_UNUSED, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0);
        do_request(CMD_INIT, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0);

        // A request landing while a write is under way is dropped.
        send_word(make_word(CMD_CHAR, 8'h41, 1'b0, 1'b0, 1'b0, 6'd0));
        send_word(make_word(CMD_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0));
        wait_idle();

        run_phase(8'd1, 8'd1, 24'd1, 25, 1'b0);
        run_phase(8'd0, 8'd0, 24'd0, 25, 1'b1);
        run_phase(8'd3, 8'd2, 24'd20, 25, 1'b0);
        run_phase(8'd1, 8'd6, 24'd5, 25, 1'b0);
        run_phase(8'd6, 8'd1, 24'd2, 25, 1'b1);
        run_phase(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                  24'($urandom_range(1, 50)), 25, 1'b0);
        run_phase(ENABLE_HIGH_RESET, ENABLE_LOW_RESET, 24'd10, 25, 1'b0);

        drain();
        repeat (20)
            @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
hdl/lcdbs_pkg.sv
hdl/lcdbs_fifo.sv
hdl/lcdbs_front.sv
hdl/lcdbs_back.sv
hdl/char_lcd_bus_sequencer_unit.sv
hdl/lcdbs_checker.sv
verif/lcd_pin_checker.sv
verif/char_lcd_bus_sequencer_unit_tb.sv
